[hdl/tcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the trixel child classifier
// Child index codes, the default coordinate width and the pipeline depth.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Default coordinate width (signed Q2.30 at 32 bits)
    localparam int TCC_COORD_WIDTH = 32;

    // Number of register stages from input capture to output register
    localparam int TCC_STAGES = 8;

    // Child index encoding
    localparam int CHILD_W = 3;
    typedef logic [CHILD_W-1:0] child_idx_t;

    localparam child_idx_t CHILD_0    = 3'd0;
    localparam child_idx_t CHILD_1    = 3'd1;
    localparam child_idx_t CHILD_2    = 3'd2;
    localparam child_idx_t CHILD_3    = 3'd3;
    localparam child_idx_t CHILD_NONE = 3'd4;

    // One containment hit per child, bit n for child n
    typedef logic [3:0] child_hit_t;

endpackage : tcc_pkg
`default_nettype wire

[hdl/trixel_child_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trixel_child_classifier: point-in-child-trixel classifier
// Finds which of the four children of a spherical triangle holds a point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid / s_ready) carries one triangle (three vertex
//   vectors) and one query point per transfer, all signed Q2.30 of
//   COORD_WIDTH bits. Result channel (m_valid / m_ready) returns one
//   child index per input transfer, in order: 0..3 for the first child
//   whose edge triple products are all strictly positive, 4 for none.
//   Throughput is one item per cycle while the receiver does not stall,
//   set by the eight-stage pipeline; every stage holds one item with its
//   own valid bit.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling empty slots, so s_ready stays high until
//   all eight stages are occupied.
//   Reset (aresetn low, synchronous) empties every stage; no result is
//   pending afterwards. Arithmetic is exact: no rounding, no saturation.
// ----------------------------------------------------------------------------
module trixel_child_classifier
    import tcc_pkg::*;
#(
    parameter int COORD_WIDTH = TCC_COORD_WIDTH
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [COORD_WIDTH-1:0] s_vert0_x,
    input  wire signed [COORD_WIDTH-1:0] s_vert0_y,
    input  wire signed [COORD_WIDTH-1:0] s_vert0_z,
    input  wire signed [COORD_WIDTH-1:0] s_vert1_x,
    input  wire signed [COORD_WIDTH-1:0] s_vert1_y,
    input  wire signed [COORD_WIDTH-1:0] s_vert1_z,
    input  wire signed [COORD_WIDTH-1:0] s_vert2_x,
    input  wire signed [COORD_WIDTH-1:0] s_vert2_y,
    input  wire signed [COORD_WIDTH-1:0] s_vert2_z,
    input  wire signed [COORD_WIDTH-1:0] s_point_x,
    input  wire signed [COORD_WIDTH-1:0] s_point_y,
    input  wire signed [COORD_WIDTH-1:0] s_point_z,
    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output child_idx_t                   m_child_index
);

    // Widths of the exact intermediate values
    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W;        // vertex component product
    localparam int CW = 2 * W + 1;    // cross product component
    localparam int HW = CW - W;       // upper slice of a cross component
    localparam int QW = 2 * W + 1;    // partial product of a slice and p
    localparam int TW = 3 * W + 1;    // cross component times p
    localparam int DW = 3 * W + 3;    // triple product
    localparam int XW = 3 * W + 5;    // signed combination of triple products
    localparam int NS = TCC_STAGES;

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or moves on
    // ------------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: capture vertices and point
    // ------------------------------------------------------------------------
    logic signed [W-1:0] vert_reg [3][3];
    logic signed [W-1:0] pnt0_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            vert_reg[0][0] <= s_vert0_x;
            vert_reg[0][1] <= s_vert0_y;
            vert_reg[0][2] <= s_vert0_z;
            vert_reg[1][0] <= s_vert1_x;
            vert_reg[1][1] <= s_vert1_y;
            vert_reg[1][2] <= s_vert1_z;
            vert_reg[2][0] <= s_vert2_x;
            vert_reg[2][1] <= s_vert2_y;
            vert_reg[2][2] <= s_vert2_z;
            pnt0_reg[0]    <= s_point_x;
            pnt0_reg[1]    <= s_point_y;
            pnt0_reg[2]    <= s_point_z;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: component products of the edge cross products
    //   edge 0: A = v0 x v1, edge 1: B = v1 x v2, edge 2: C = v2 x v0
    //   comp k = u[k+1]*w[k+2] - u[k+2]*w[k+1]
    // Midpoint crosses reduce to sums of A, B and C, so only these are needed.
    // ------------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg [3][3][2];
    logic signed [W-1:0]  pnt1_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[e][k][0] <=
                        vert_reg[e][(k == 2) ? 0 : k + 1] *
                        vert_reg[(e == 2) ? 0 : e + 1][(k == 0) ? 2 : k - 1];
                    prod_reg[e][k][1] <=
                        vert_reg[e][(k == 0) ? 2 : k - 1] *
                        vert_reg[(e == 2) ? 0 : e + 1][(k == 2) ? 0 : k + 1];
                end
            end
            pnt1_reg <= pnt0_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: cross product components
    // ------------------------------------------------------------------------
    logic signed [CW-1:0] crs_reg  [3][3];
    logic signed [W-1:0]  pnt2_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    crs_reg[e][k] <= CW'(prod_reg[e][k][0]) - CW'(prod_reg[e][k][1]);
                end
            end
            pnt2_reg <= pnt1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: cross component times point, split in two partial products
    //   low slice: W bits unsigned, high slice: HW bits signed
    // ------------------------------------------------------------------------
    logic signed [QW-1:0] plo_reg [3][3];
    logic signed [QW-1:0] phi_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    plo_reg[e][k] <= $signed({1'b0, crs_reg[e][k][W-1:0]}) * pnt2_reg[k];
                    phi_reg[e][k] <= $signed(crs_reg[e][k][CW-1:W]) * pnt2_reg[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: recombine the partial products
    // ------------------------------------------------------------------------
    logic signed [TW-1:0] trm_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    trm_reg[e][k] <= $signed({phi_reg[e][k][QW-HW-1+HW-1:0], {W{1'b0}}})
                                   + TW'(plo_reg[e][k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: triple products a = A.p, b = B.p, c = C.p
    // ------------------------------------------------------------------------
    logic signed [DW-1:0] dot_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            for (int e = 0; e < 3; e++) begin
                dot_reg[e] <= DW'(trm_reg[e][0]) + DW'(trm_reg[e][1]) + DW'(trm_reg[e][2]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: strict sign tests per child
    //   child 0: a, b-a-c, c      child 1: b, c-a-b, a
    //   child 2: c, a-b-c, b      child 3: b+c-a, a+c-b, a+b-c
    // ------------------------------------------------------------------------
    logic signed [XW-1:0] xa, xb, xc;
    logic signed [XW-1:0] q0, q1, q2, r0, r1, r2;
    logic                 pa, pb, pc;
    child_hit_t           hit_next;
    child_hit_t           hit_reg;

    function automatic logic is_pos(input logic signed [XW-1:0] v);
        return !v[XW-1] && (v != '0);
    endfunction

    always_comb begin
        xa = XW'(dot_reg[0]);
        xb = XW'(dot_reg[1]);
        xc = XW'(dot_reg[2]);
        q0 = xb - xa - xc;
        q1 = xc - xa - xb;
        q2 = xa - xb - xc;
        r0 = xb + xc - xa;
        r1 = xa + xc - xb;
        r2 = xa + xb - xc;
        pa = is_pos(xa);
        pb = is_pos(xb);
        pc = is_pos(xc);
        hit_next[0] = pa && is_pos(q0) && pc;
        hit_next[1] = pb && is_pos(q1) && pa;
        hit_next[2] = pc && is_pos(q2) && pb;
        hit_next[3] = is_pos(r0) && is_pos(r1) && is_pos(r2);
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            hit_reg <= hit_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: first matching child into the output register
    // ------------------------------------------------------------------------
    child_idx_t idx_next;
    child_idx_t idx_reg;

    always_comb begin
        priority if (hit_reg[0]) begin
            idx_next = CHILD_0;
        end else if (hit_reg[1]) begin
            idx_next = CHILD_1;
        end else if (hit_reg[2]) begin
            idx_next = CHILD_2;
        end else if (hit_reg[3]) begin
            idx_next = CHILD_3;
        end else begin
            idx_next = CHILD_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            idx_reg <= idx_next;
        end
    end

    assign m_child_index = idx_reg;

`ifndef ASSERT_OFF
    // no result pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a full pipeline with a stalled output takes no new item
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    // a child 0 hit loaded into the output register reports child 0
    a_child0_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv[7] && vld_reg[6] && hit_reg[0]) |=> (m_child_index == CHILD_0))
        else $error("child 0 hit not reported first");

    // result code stays within the defined range
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_child_index <= CHILD_NONE))
        else $error("child index out of range");
`endif

endmodule : trixel_child_classifier
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for trixel_child_classifier
// Drives triangle/point transfers, predicts the child index with exact
// wide-integer triple products, and checks every result in order under
// several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import tcc_pkg::*;

    localparam int W           = TCC_COORD_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * TCC_STAGES + 4;

    typedef logic [W-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;
    typedef struct packed {
        vec_t v0;
        vec_t v1;
        vec_t v2;
        vec_t p;
    } tri_item_t;

    // wide enough for exact triple products of midpoint-sized operands
    typedef logic signed [127:0] wide_t;
    typedef struct {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    tri_item_t  s_item  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    child_idx_t m_child_index;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    child_idx_t expected_child_q[$];

    trixel_child_classifier #(
        .COORD_WIDTH(W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vert0_x    (s_item.v0.x),
        .s_vert0_y    (s_item.v0.y),
        .s_vert0_z    (s_item.v0.z),
        .s_vert1_x    (s_item.v1.x),
        .s_vert1_y    (s_item.v1.y),
        .s_vert1_z    (s_item.v1.z),
        .s_vert2_x    (s_item.v2.x),
        .s_vert2_y    (s_item.v2.y),
        .s_vert2_z    (s_item.v2.z),
        .s_point_x    (s_item.p.x),
        .s_point_y    (s_item.p.y),
        .s_point_z    (s_item.p.z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_child_index(m_child_index)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Child index predictor
    // ------------------------------------------------------------------
    function automatic wvec_t widen(vec_t v);
        wvec_t r;
        r.x = $signed(v.x);
        r.y = $signed(v.y);
        r.z = $signed(v.z);
        return r;
    endfunction

    function automatic wvec_t wsum(wvec_t a, wvec_t b);
        wvec_t r;
        r.x = a.x + b.x;
        r.y = a.y + b.y;
        r.z = a.z + b.z;
        return r;
    endfunction

    // (a x b) . p > 0, exact
    function automatic logic triple_positive(wvec_t a, wvec_t b, wvec_t p);
        wide_t cx, cy, cz, d;
        cx = a.y * b.z - a.z * b.y;
        cy = a.z * b.x - a.x * b.z;
        cz = a.x * b.y - a.y * b.x;
        d  = cx * p.x + cy * p.y + cz * p.z;
        return d > 0;
    endfunction

    function automatic logic cone_holds(wvec_t a, wvec_t b, wvec_t c, wvec_t p);
        return triple_positive(a, b, p) && triple_positive(b, c, p)
            && triple_positive(c, a, p);
    endfunction

    function automatic child_idx_t classify_point(tri_item_t it);
        wvec_t v0, v1, v2, p, m0, m1, m2;
        v0 = widen(it.v0);
        v1 = widen(it.v1);
        v2 = widen(it.v2);
        p  = widen(it.p);
        m0 = wsum(v1, v2);
        m1 = wsum(v0, v2);
        m2 = wsum(v0, v1);
        if (cone_holds(v0, m2, m1, p))
            return CHILD_0;
        else if (cone_holds(v1, m0, m2, p))
            return CHILD_1;
        else if (cone_holds(v2, m1, m0, p))
            return CHILD_2;
        else if (cone_holds(m0, m1, m2, p))
            return CHILD_3;
        return CHILD_NONE;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic vec_t mk_vec(int x, int y, int z);
        vec_t v;
        v.x = coord_t'(x);
        v.y = coord_t'(y);
        v.z = coord_t'(z);
        return v;
    endfunction

    function automatic tri_item_t mk_item(vec_t v0, vec_t v1, vec_t v2, vec_t p);
        tri_item_t it;
        it.v0 = v0;
        it.v1 = v1;
        it.v2 = v2;
        it.p  = p;
        return it;
    endfunction

    function automatic tri_item_t fill_item(coord_t c);
        tri_item_t it;
        it = {12{c}};
        return it;
    endfunction

    // component in [-2^30, 2^30], optionally a multiple of 32 so that the
    // blended point below is an exact positive combination
    function automatic coord_t rand_coord(logic aligned);
        coord_t c;
        c = coord_t'($urandom_range(32'h8000_0000, 0) - 32'h4000_0000);
        if (aligned)
            c[4:0] = '0;
        return c;
    endfunction

    function automatic vec_t rand_vertex(logic aligned);
        vec_t v;
        v.x = rand_coord(aligned);
        v.y = rand_coord(aligned);
        v.z = rand_coord(aligned);
        return v;
    endfunction

    // (w0*a + w1*b + w2*c) / 32, weights up to 15 keep it within range
    function automatic coord_t blend(coord_t a, coord_t b, coord_t c,
                                     int w0, int w1, int w2);
        logic signed [63:0] sa, sb, sc, s;
        sa = $signed(a);
        sb = $signed(b);
        sc = $signed(c);
        s  = sa * w0 + sb * w1 + sc * w2;
        s  = s >>> 5;
        return coord_t'(s);
    endfunction

    // random triangle, mostly counterclockwise, point mostly inside its cone
    function automatic tri_item_t make_cone_item();
        tri_item_t it;
        vec_t      tmp;
        logic      aligned;
        int        w0, w1, w2;
        aligned = 1'($urandom_range(1, 0));
        it.v0   = rand_vertex(aligned);
        it.v1   = rand_vertex(aligned);
        it.v2   = rand_vertex(aligned);
        if (!triple_positive(widen(it.v0), widen(it.v1), widen(it.v2))
                && $urandom_range(9, 0) != 0) begin
            tmp   = it.v1;
            it.v1 = it.v2;
            it.v2 = tmp;
        end
        w0 = $urandom_range(15, 0);
        w1 = $urandom_range(15, 0);
        w2 = $urandom_range(15, 0);
        // equal weights for v0 and v1 put the point on the plane through v2 and the v0-v1 midpoint
        if ($urandom_range(15, 0) == 0)
            w1 = w0;
        it.p.x = blend(it.v0.x, it.v1.x, it.v2.x, w0, w1, w2);
        it.p.y = blend(it.v0.y, it.v1.y, it.v2.y, w0, w1, w2);
        it.p.z = blend(it.v0.z, it.v1.z, it.v2.z, w0, w1, w2);
        // antipodal point, outside the cone when the triangle is counterclockwise
        if ($urandom_range(9, 0) == 0) begin
            it.p.x = -it.p.x;
            it.p.y = -it.p.y;
            it.p.z = -it.p.z;
        end
        return it;
    endfunction

    // raw bit patterns on every field
    function automatic tri_item_t make_noise_item();
        tri_item_t it;
        for (int i = 0; i < 12; i++)
            it[i*W +: W] = coord_t'($urandom());
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Transfer driver
    // ------------------------------------------------------------------
    task automatic send_item(tri_item_t it);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic wait_results_drained();
        do
            @(posedge aclk);
        while (expected_child_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall generator
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Prediction on input transfer, compare on result transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        child_idx_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_child_q.push_back(classify_point(s_item));
            if (m_valid && m_ready) begin
                if (expected_child_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual %0d",
                             $time, m_child_index);
                end else begin
                    want = expected_child_q.pop_front();
                    if (m_child_index !== want) begin
                        mismatch_count++;
                        $display("%0t: child_index mismatch, expected %0d actual %0d",
                                 $time, want, m_child_index);
                    end
                end
            end
        end
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("trixel_child_classifier verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // field extremes and raw patterns
    task automatic test_field_extremes();
        send_item(fill_item('0));
        send_item(fill_item(coord_t'(32'h4000_0000)));
        send_item(fill_item(coord_t'(32'hC000_0000)));
        send_item(fill_item(coord_t'(32'h7FFF_FFFF)));
        send_item(fill_item(coord_t'(32'h8000_0000)));
        send_item(fill_item(coord_t'(32'h5555_5555)));
        send_item(mk_item(mk_vec(32'h7FFF_FFFF, 0, 0), mk_vec(0, 32'h7FFF_FFFF, 0),
                          mk_vec(0, 0, 32'h7FFF_FFFF),
                          mk_vec(32'h8000_0000, 32'hAAAA_AAAA, 32'h8000_0000)));
    endtask

    // octant triangle, one point per child plus outside and reversed
    task automatic test_octant_children();
        vec_t vx, vy, vz;
        int   k;
        k  = 1 << 26;
        vx = mk_vec(1 << 30, 0, 0);
        vy = mk_vec(0, 1 << 30, 0);
        vz = mk_vec(0, 0, 1 << 30);
        send_item(mk_item(vx, vy, vz, mk_vec(6 * k, k, k)));
        send_item(mk_item(vx, vy, vz, mk_vec(k, 6 * k, k)));
        send_item(mk_item(vx, vy, vz, mk_vec(k, k, 6 * k)));
        send_item(mk_item(vx, vy, vz, mk_vec(k, k, k)));
        send_item(mk_item(vx, vy, vz, mk_vec(-k, k, k)));
        send_item(mk_item(vx, vz, vy, mk_vec(k, k, k)));
    endtask

    // point on a vertex, an edge midpoint and a child boundary
    task automatic test_boundary_points();
        vec_t vx, vy, vz;
        int   k;
        k  = 1 << 26;
        vx = mk_vec(1 << 30, 0, 0);
        vy = mk_vec(0, 1 << 30, 0);
        vz = mk_vec(0, 0, 1 << 30);
        send_item(mk_item(vx, vy, vz, vx));
        send_item(mk_item(vx, vy, vz, mk_vec(k, k, 0)));
        send_item(mk_item(vx, vy, vz, mk_vec(2 * k, k, k)));
    endtask

    // zero midpoint, repeated vertices, collinear vertices
    task automatic test_degenerate_triangles();
        vec_t va, vb, pt;
        int   k;
        k  = 1 << 27;
        va = mk_vec(3 * k, k, 2 * k);
        vb = mk_vec(-k, 3 * k, k);
        pt = mk_vec(k, k, k);
        send_item(mk_item(va, vb, mk_vec(k, -3 * k, -k), pt));
        send_item(mk_item(va, va, va, va));
        send_item(mk_item(va, va, vb, pt));
    endtask

    task automatic test_random_traffic(int n, int src_pct, int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n) begin
            if ($urandom_range(99, 0) < 85)
                send_item(make_cone_item());
            else
                send_item(make_noise_item());
        end
    endtask

    // sender holds off until the pipeline is empty
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_octant_children();
        test_boundary_points();
        test_degenerate_triangles();

        test_random_traffic(290, 0, 0);
        test_drain_pause();
        test_random_traffic(285, 47, 0);
        test_random_traffic(285, 0, 47);
        test_drain_pause();
        test_random_traffic(290, 31, 31);

        s_valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && expected_child_q.size() == 0)
            $display("trixel_child_classifier verification clean");
        else
            $display("trixel_child_classifier verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/tcc_pkg.sv
hdl/trixel_child_classifier.sv
tb/tb.sv
